### hdl/n2a_pkg.sv
package n2a_pkg;

    // format classes carried from the front end to the emitter
    typedef enum logic [1:0] {
        FMT_BIN,
        FMT_HEX,
        FMT_RAW,
        FMT_DEC
    } fmt_t;

    localparam logic [7:0] ACT_BIN  = 8'h62;  // 'b'
    localparam logic [7:0] ACT_CHR  = 8'h63;  // 'c'
    localparam logic [7:0] ACT_DEC  = 8'h64;  // 'd'
    localparam logic [7:0] ACT_HEX4 = 8'h6d;  // 'm'
    localparam logic [7:0] ACT_HEX2 = 8'h78;  // 'x'

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;

    localparam int DEC_DIGITS = 5;

    // one queued job: byte data is left aligned so the emitter reads its top bits
    typedef struct packed {
        fmt_t        fmt;
        logic [15:0] data;
        logic [3:0]  count;
        logic [2:0]  widx;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // multiples 0..9 of each decimal weight, most significant weight first
    localparam logic [16:0] DEC_MULT [DEC_DIGITS][10] = '{
        '{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000,
          17'd50000, 17'd60000, 17'd70000, 17'd80000, 17'd90000},
        '{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000,
          17'd5000, 17'd6000, 17'd7000, 17'd8000, 17'd9000},
        '{17'd0, 17'd100, 17'd200, 17'd300, 17'd400,
          17'd500, 17'd600, 17'd700, 17'd800, 17'd900},
        '{17'd0, 17'd10, 17'd20, 17'd30, 17'd40,
          17'd50, 17'd60, 17'd70, 17'd80, 17'd90},
        '{17'd0, 17'd1, 17'd2, 17'd3, 17'd4,
          17'd5, 17'd6, 17'd7, 17'd8, 17'd9}
    };

    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] g;
        if (d < 4'd10)
        begin
            g = 8'h30 + {4'd0, d};
        end
        else
        begin
            g = 8'h37 + {4'd0, d};
        end
        return g;
    endfunction

endpackage

### hdl/n2a_front.sv
module n2a_front
    import n2a_pkg::*;
(
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  action,
    input  logic [15:0] value,
    input  q_status_t   q_status,
    output logic        push,
    output job_t        push_job
);

    logic [2:0] dec_start;

    assign busy = q_status.full;
    assign push = start & ~q_status.full;

    // first decimal digit position that is not a leading zero
    always_comb
    begin
        if (value >= 16'd10000)
        begin
            dec_start = 3'd0;
        end
        else if (value >= 16'd1000)
        begin
            dec_start = 3'd1;
        end
        else if (value >= 16'd100)
        begin
            dec_start = 3'd2;
        end
        else if (value >= 16'd10)
        begin
            dec_start = 3'd3;
        end
        else
        begin
            dec_start = 3'd4;
        end
    end

    always_comb
    begin
        push_job.widx = 3'd0;
        case (action)
            ACT_BIN:
            begin
                push_job.fmt   = FMT_BIN;
                push_job.data  = {value[7:0], 8'h00};
                push_job.count = 4'd8;
            end
            ACT_CHR:
            begin
                push_job.fmt   = FMT_RAW;
                push_job.data  = {value[7:0], 8'h00};
                push_job.count = 4'd1;
            end
            ACT_HEX2:
            begin
                push_job.fmt   = FMT_HEX;
                push_job.data  = {value[7:0], 8'h00};
                push_job.count = 4'd2;
            end
            ACT_HEX4:
            begin
                push_job.fmt   = FMT_HEX;
                push_job.data  = value;
                push_job.count = 4'd4;
            end
            ACT_DEC:
            begin
                push_job.fmt   = FMT_DEC;
                push_job.data  = value;
                push_job.count = 4'd5 - {1'b0, dec_start};
                push_job.widx  = dec_start;
            end
            default:
            begin
                // unknown format: echo the format character itself
                push_job.fmt   = FMT_RAW;
                push_job.data  = {action, 8'h00};
                push_job.count = 4'd1;
            end
        endcase
    end

endmodule

### hdl/n2a_queue.sv
module n2a_queue
    import n2a_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      head_job,
    output q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;

    assign status.full  = (fill_reg == CNT_W'(DEPTH));
    assign status.empty = (fill_reg == '0);
    assign head_job     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue read while empty");

endmodule

### hdl/n2a_back.sv
module n2a_back
    import n2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        head_job,
    input  q_status_t   q_status,
    output logic        pop,
    output logic        strobe,
    output logic [7:0]  ascii_char,
    output logic        last
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    fmt_t        fmt_reg;
    fmt_t        fmt_next;
    logic [15:0] data_reg;
    logic [15:0] data_next;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;
    logic [2:0]  widx_reg;
    logic [2:0]  widx_next;
    logic        strobe_reg;
    logic        strobe_next;
    logic [7:0]  char_reg;
    logic [7:0]  char_next;
    logic        last_reg;
    logic        last_next;
    logic [3:0]  dec_q;

    assign pop        = (state_reg == ST_IDLE) && !q_status.empty;
    assign strobe     = strobe_reg;
    assign ascii_char = char_reg;
    assign last       = last_reg;

    // decimal digit: count of multiples of the current weight that fit
    always_comb
    begin
        dec_q = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if ({1'b0, data_reg} >= DEC_MULT[widx_reg][k])
            begin
                dec_q = 4'(k);
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        fmt_next    = fmt_reg;
        data_next   = data_reg;
        cnt_next    = cnt_reg;
        widx_next   = widx_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    fmt_next   = head_job.fmt;
                    data_next  = head_job.data;
                    cnt_next   = head_job.count;
                    widx_next  = head_job.widx;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                last_next   = (cnt_reg == 4'd1);
                cnt_next    = cnt_reg - 1'b1;
                case (fmt_reg)
                    FMT_BIN:
                    begin
                        char_next = data_reg[15] ? CHAR_ONE : CHAR_ZERO;
                        data_next = {data_reg[14:0], 1'b0};
                    end
                    FMT_HEX:
                    begin
                        char_next = digit_glyph(data_reg[15:12]);
                        data_next = {data_reg[11:0], 4'h0};
                    end
                    FMT_DEC:
                    begin
                        char_next = digit_glyph(dec_q);
                        data_next = data_reg - DEC_MULT[widx_reg][dec_q][15:0];
                        widx_next = widx_reg + 1'b1;
                    end
                    default:
                    begin
                        char_next = data_reg[15:8];
                    end
                endcase
                if (cnt_reg == 4'd1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fmt_reg    <= FMT_RAW;
            data_reg   <= '0;
            cnt_reg    <= '0;
            widx_reg   <= '0;
            strobe_reg <= 1'b0;
            char_reg   <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fmt_reg    <= fmt_next;
            data_reg   <= data_next;
            cnt_reg    <= cnt_next;
            widx_reg   <= widx_next;
            strobe_reg <= strobe_next;
            char_reg   <= char_next;
            last_reg   <= last_next;
        end
    end

    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> cnt_reg != 4'd0)
        else $error("emitting with no characters left");

    a_dec_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && fmt_reg == FMT_DEC) |-> (widx_reg <= 3'd4 && dec_q <= 4'd9))
        else $error("decimal digit out of range");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !last_reg) |-> $past(state_next == ST_EMIT))
        else $error("non-final word not followed by more characters");

endmodule

### hdl/number_to_ascii_formatter.sv
// number to ascii formatter
//
// command in: action (format character) and value are taken at a clock edge
// with start high and busy low. 'b' eight binary digits of the low byte,
// 'c' the low byte itself, 'd' unsigned decimal without leading zeros,
// 'x' two hex digits of the low byte, 'm' four hex digits of value; any
// other action is echoed as one character.
// result out: while a command is emitted, one character word per cycle on
// ascii_char with strobe high; last marks the final word of a command.
// the receiver cannot stall. a command is written into the queue, loaded
// by the emitter and sent out through the registered character output; the
// emitter pops a command only once the previous one has sent its last word.
// commands wait in a QUEUE_DEPTH entry queue; busy is high while it is full.
// reset clears the queue and the emitter; no command state survives.
module number_to_ascii_formatter
    import n2a_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  action,
    input  logic [15:0] value,
    output logic        strobe,
    output logic [7:0]  ascii_char,
    output logic        last
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    job_t      push_job;
    job_t      head_job;

    n2a_front u_front (
        .start    (start),
        .busy     (busy),
        .action   (action),
        .value    (value),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    n2a_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    n2a_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .q_status   (q_status),
        .pop        (pop),
        .strobe     (strobe),
        .ascii_char (ascii_char),
        .last       (last)
    );

endmodule

### tb/sv/number_to_ascii_formatter_test.sv
module number_to_ascii_formatter_test
    import n2a_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_WORDS  = 470;
    localparam int DRAIN_CYCLES  = 20;
    localparam logic [7:0] HEX_TEN = 8'h41;  // 'A'

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } char_word_t;

    class ascii_expectation;
        char_word_t pending_chars[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        function logic [7:0] hex_char(input logic [3:0] nib);
            logic [7:0] c;
            if (nib < 4'd10)
            begin
                c = CHAR_ZERO + {4'd0, nib};
            end
            else
            begin
                c = HEX_TEN + {4'd0, nib} - 8'd10;
            end
            return c;
        endfunction

        // expected character run for one accepted command word
        function void note_command(input logic [7:0] act, input logic [15:0] val);
            logic [7:0] run[8];
            int         n;
            int         rem;
            int         weight;
            int         digit;
            bit         seen;
            n = 0;
            case (act)
                ACT_BIN:
                begin
                    for (int i = 7; i >= 0; i--)
                    begin
                        run[n] = val[i] ? CHAR_ONE : CHAR_ZERO;
                        n++;
                    end
                end
                ACT_CHR:
                begin
                    run[0] = val[7:0];
                    n = 1;
                end
                ACT_DEC:
                begin
                    rem = int'(val);
                    weight = 10000;
                    seen = 0;
                    for (int i = 0; i < DEC_DIGITS; i++)
                    begin
                        digit = rem / weight;
                        rem = rem % weight;
                        // leading zeros dropped, but the units digit always shows
                        if (digit != 0 || seen || weight == 1)
                        begin
                            run[n] = hex_char(digit[3:0]);
                            n++;
                            seen = 1;
                        end
                        weight = weight / 10;
                    end
                end
                ACT_HEX2:
                begin
                    run[0] = hex_char(val[7:4]);
                    run[1] = hex_char(val[3:0]);
                    n = 2;
                end
                ACT_HEX4:
                begin
                    run[0] = hex_char(val[15:12]);
                    run[1] = hex_char(val[11:8]);
                    run[2] = hex_char(val[7:4]);
                    run[3] = hex_char(val[3:0]);
                    n = 4;
                end
                default:
                begin
                    run[0] = act;
                    n = 1;
                end
            endcase
            for (int i = 0; i < n; i++)
            begin
                pending_chars.push_back('{ch: run[i], fin: (i == n - 1)});
            end
        endfunction

        function void check_char(input logic [7:0] ch, input logic fin);
            char_word_t want;
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected word ascii_char=%h last=%b", $time, ch, fin);
                errors++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (ch !== want.ch)
                begin
                    $display("%0t: ascii_char expected %h actual %h", $time, want.ch, ch);
                    errors++;
                end
                if (fin !== want.fin)
                begin
                    $display("%0t: last expected %b actual %b", $time, want.fin, fin);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  action;
    logic [15:0] value;
    logic        strobe;
    logic [7:0]  ascii_char;
    logic        last;

    ascii_expectation expected_text;
    int               cycle_count;
    int               idle_pct;

    number_to_ascii_formatter i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .value      (value),
        .strobe     (strobe),
        .ascii_char (ascii_char),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("number_to_ascii_formatter_test: errors");
            $finish;
        end
    end

    // outputs sampled before the edge updates them
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            expected_text.check_char(ascii_char, last);
        end
    end

    // called just after an edge; returns after the accepting edge and any idle gap
    task automatic send_command(input logic [7:0] act, input logic [15:0] val);
        int gap;
        start  <= 1'b1;
        action <= act;
        value  <= val;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        expected_text.note_command(act, val);
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [15:0] pick_value();
        logic [15:0] v;
        case ($urandom_range(3))
            0: v = 16'($urandom_range(255));
            1: v = 16'($urandom_range(99));
            2:
            begin
                case ($urandom_range(9))
                    0: v = 16'd0;
                    1: v = 16'd9;
                    2: v = 16'd10;
                    3: v = 16'd99;
                    4: v = 16'd100;
                    5: v = 16'd999;
                    6: v = 16'd1000;
                    7: v = 16'd9999;
                    8: v = 16'd10000;
                    default: v = 16'hffff;
                endcase
            end
            default: v = 16'($urandom_range(16'hffff));
        endcase
        return v;
    endfunction

    function automatic logic [7:0] pick_action();
        logic [7:0] a;
        case ($urandom_range(9))
            0, 1: a = ACT_DEC;
            2:    a = ACT_BIN;
            3:    a = ACT_CHR;
            4:    a = ACT_HEX2;
            5:    a = ACT_HEX4;
            6, 7: a = ACT_DEC;
            default: a = 8'($urandom_range(255));
        endcase
        return a;
    endfunction

    initial
    begin
        int phase_pct[4];
        expected_text = new();
        cycle_count = 0;
        idle_pct = 0;
        phase_pct = '{0, 74, 0, 27};
        rst_n  = 1'b0;
        start  <= 1'b0;
        action <= 8'd0;
        value  <= 16'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, every format, zero and wide values
        send_command(ACT_BIN, 16'h0000);
        send_command(ACT_BIN, 16'hffff);
        send_command(ACT_BIN, 16'h5aa5);
        send_command(ACT_CHR, 16'h0000);
        send_command(ACT_CHR, 16'hffff);
        send_command(ACT_CHR, 16'h1241);
        send_command(ACT_DEC, 16'd0);
        send_command(ACT_DEC, 16'd9);
        send_command(ACT_DEC, 16'd10);
        send_command(ACT_DEC, 16'd100);
        send_command(ACT_DEC, 16'd9999);
        send_command(ACT_DEC, 16'd10000);
        send_command(ACT_DEC, 16'd65535);
        send_command(ACT_DEC, 16'd40302);
        send_command(ACT_HEX2, 16'h0000);
        send_command(ACT_HEX2, 16'hffff);
        send_command(ACT_HEX2, 16'hab3c);
        send_command(ACT_HEX4, 16'h0000);
        send_command(ACT_HEX4, 16'hffff);
        send_command(ACT_HEX4, 16'h1a2b);
        send_command(8'h00, 16'h1234);
        send_command(8'hff, 16'h0000);
        send_command(8'h61, 16'hffff);
        send_command(8'h7a, 16'h00ff);

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_pct[p];
            for (int i = 0; i < RANDOM_WORDS / 4; i++)
            begin
                send_command(pick_action(), pick_value());
            end
        end
        start <= 1'b0;

        while (expected_text.pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_text.errors == 0 && expected_text.pending_chars.size() == 0)
        begin
            $display("number_to_ascii_formatter_test: clean");
        end
        else
        begin
            $display("number_to_ascii_formatter_test: errors");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/n2a_pkg.sv
hdl/n2a_front.sv
hdl/n2a_queue.sv
hdl/n2a_back.sv
hdl/number_to_ascii_formatter.sv
tb/sv/number_to_ascii_formatter_test.sv
